>>> hw/rtl/ifd_pkg.sv
package ifd_pkg;

    localparam int FRAME_BYTES = 57;
    localparam int WORD_COUNT  = 6;
    localparam int WORD_BYTES  = 24;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int OUT_W       = WORD_COUNT * WORD_W;

    localparam logic [7:0]        SYNC_BYTE  = 8'h5a;
    localparam logic [7:0]        LAST_INDEX = 8'(FRAME_BYTES - 1);
    localparam logic [7:0]        DATA_END   = 8'(WORD_BYTES);
    localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(WORD_COUNT - 1);

    typedef enum logic [1:0] {
        PH_HUNT1   = 2'd0,
        PH_HUNT2   = 2'd1,
        PH_COLLECT = 2'd2
    } ifd_phase_t;

    // One word write into the sample store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } ifd_wr_t;

    // Read side of the sample store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ifd_rd_t;

    typedef struct packed {
        logic pend;
        logic busy;
        logic cap_last;
    } ifd_rd_stat_t;

endpackage

>>> hw/rtl/ifd_ram.sv
module ifd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ifd_parser.sv
module ifd_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    output ifd_pkg::ifd_wr_t wr,
    output logic           frame_good
);
    import ifd_pkg::*;

    ifd_phase_t  phase_reg, phase_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [23:0] asm_reg, asm_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT1;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
        asm_reg <= asm_next;
    end

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        asm_next   = asm_reg;
        wr         = '0;
        frame_good = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT2: begin
                    // A failed second sync byte is not retried as a first one.
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_COLLECT : PH_HUNT1;
                    idx_next   = '0;
                    sum_next   = '0;
                end
                PH_COLLECT: begin
                    if (idx_reg < DATA_END) begin
                        // Little-endian assembly: each new byte enters at the top.
                        asm_next = {rx_byte, asm_reg[23:8]};
                        if (idx_reg[1:0] == 2'b11) begin
                            wr.en   = 1'b1;
                            wr.addr = idx_reg[2 +: ADDR_W];
                            wr.data = {rx_byte, asm_reg[23:0]};
                        end
                    end
                    if (idx_reg == LAST_INDEX) begin
                        frame_good = (rx_byte == sum_reg);
                        phase_next = PH_HUNT1;
                        idx_next   = '0;
                        sum_next   = '0;
                    end else begin
                        sum_next = sum_reg + rx_byte;
                        idx_next = idx_reg + 8'd1;
                    end
                end
                default: begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ifd_readout.sv
module ifd_readout (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      frame_good,
    output ifd_pkg::ifd_rd_t          rd,
    input  logic [ifd_pkg::WORD_W-1:0] rd_data,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ifd_pkg::OUT_W-1:0] m_tdata,
    output logic                      hold,
    output ifd_pkg::ifd_rd_stat_t     stat
);
    import ifd_pkg::*;

    logic                                pend_reg, pend_next;
    logic                                busy_reg, busy_next;
    logic [ADDR_W-1:0]                   addr_reg, addr_next;
    logic                                cap_v_reg;
    logic [ADDR_W-1:0]                   cap_idx_reg;
    logic                                tvalid_reg, tvalid_next;
    logic [WORD_COUNT-1:0][WORD_W-1:0]   tdata_reg, tdata_next;
    logic                                start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            addr_reg   <= '0;
            cap_v_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            pend_reg   <= pend_next;
            busy_reg   <= busy_next;
            addr_reg   <= addr_next;
            cap_v_reg  <= rd.en;
            tvalid_reg <= tvalid_next;
        end
        cap_idx_reg <= rd.addr;
        tdata_reg   <= tdata_next;
    end

    // The sweep starts only once the output word has been taken.
    assign start = pend_reg && !tvalid_reg;

    always_comb begin
        pend_next   = (pend_reg && !start) || frame_good;
        busy_next   = busy_reg;
        addr_next   = addr_reg;
        rd          = '0;
        tvalid_next = tvalid_reg && !m_tready;
        tdata_next  = tdata_reg;
        if (start) begin
            rd.en     = 1'b1;
            rd.addr   = '0;
            busy_next = 1'b1;
            addr_next = ADDR_W'(1);
        end else if (busy_reg) begin
            rd.en   = 1'b1;
            rd.addr = addr_reg;
            if (addr_reg == LAST_WORD) begin
                busy_next = 1'b0;
            end else begin
                addr_next = addr_reg + ADDR_W'(1);
            end
        end
        if (cap_v_reg) begin
            tdata_next[cap_idx_reg] = rd_data;
            if (cap_idx_reg == LAST_WORD) begin
                tvalid_next = 1'b1;
            end
        end
    end

    assign m_tvalid      = tvalid_reg;
    assign m_tdata       = tdata_reg;
    assign hold          = pend_reg && tvalid_reg;
    assign stat.pend     = pend_reg;
    assign stat.busy     = busy_reg;
    assign stat.cap_last = cap_v_reg && (cap_idx_reg == LAST_WORD);

endmodule

>>> hw/rtl/imu_frame_deframer_unit.sv
// Sensor link deframer. The slave channel takes one received byte per word
// (s_tdata) and may deliver a word in every cycle. The block hunts for the
// sync pair 0x5a 0x5a, collects a 57-byte frame and checks its last byte
// against the modulo-256 sum of the 56 bytes before it. A good frame gives
// one master word carrying the six 32-bit sample patterns (gyro x, y, z,
// accel x, y, z); a bad frame is dropped with no output.
// Samples are packed into 32-bit words and kept in a small six-entry RAM.
// After the last byte of a good frame, once no earlier result is held, the six
// words are read out, one per cycle, and m_tvalid rises once the last is captured.
// Throughput is one input byte per cycle while s_tready is high; frames are at
// least 59 bytes apart, which leaves the readout ample time.
// While a result waits on m_tready the block still takes input bytes; only
// when a second good frame has finished behind it does s_tready drop, until
// the held result is taken and the new readout starts.
// Reset (aresetn low, synchronous) returns to the hunt for the first sync
// byte and empties the output; the sample RAM itself is not cleared.
module imu_frame_deframer_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // [7:0] rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] gyro_x_bits, [63:32] gyro_y_bits, [95:64] gyro_z_bits,
    // [127:96] accel_x_bits, [159:128] accel_y_bits, [191:160] accel_z_bits
    output logic [ifd_pkg::OUT_W-1:0] m_tdata
);
    import ifd_pkg::*;

    logic         accept;
    logic         frame_good;
    logic         hold;
    ifd_wr_t      wr;
    ifd_rd_t      rd;
    ifd_rd_stat_t stat;
    logic [WORD_W-1:0] rd_data;

    assign s_tready = !hold;
    assign accept   = s_tvalid && s_tready;

    ifd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .wr         (wr),
        .frame_good (frame_good)
    );

    ifd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (rd.addr),
        .rd_data (rd_data)
    );

    ifd_readout u_readout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_good (frame_good),
        .rd         (rd),
        .rd_data    (rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .hold       (hold),
        .stat       (stat)
    );

`ifndef SYNTHESIS
    // A good frame can never finish while an earlier one is still queued or read.
    a_good_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_good |-> (!stat.busy && !stat.pend))
        else $error("frame completed during readout");

    // A new frame must not overwrite the word being read out.
    a_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("sample store write and read collide");

    // Capturing the last word presents the result on the next cycle.
    a_cap_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.cap_last |=> m_tvalid)
        else $error("result not presented after readout");

    a_good_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_good |=> stat.pend)
        else $error("good frame not queued for readout");
`endif

endmodule
